// ===== rtl/fir3b_pkg.sv =====
// Shared types, constants and coefficient tables of the three-bank FIR filter.
`timescale 1ns / 1ps

package fir3b_pkg;

	localparam int TAPS       = 35;
	localparam int HALF_TAPS  = 18;
	localparam int HIST_LEN   = TAPS - 1;
	localparam int NUM_BANKS  = 3;
	localparam int GROUP_LEN  = 6;
	localparam int NUM_GROUPS = HALF_TAPS / GROUP_LEN;
	localparam int Q23_BITS   = 24;

	// Filter mode register codes; the unused code selects the low-pass bank.
	localparam logic [1:0] MODE_LOW_PASS  = 2'd0;
	localparam logic [1:0] MODE_BAND_PASS = 2'd1;
	localparam logic [1:0] MODE_HIGH_PASS = 2'd2;

	typedef enum logic [1:0] {
		BANK_LP = 2'd0,
		BANK_BP = 2'd1,
		BANK_HP = 2'd2
	} bank_sel_t;

	// Stage load enables and input take, driven by the top level's flow control.
	typedef struct packed {
		logic take_in;
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic load_out;
	} pipe_ctl_t;

	// First half of each symmetric bank, signed Q1.23.
	localparam logic signed [Q23_BITS-1:0] COEF_Q23 [NUM_BANKS][HALF_TAPS] = '{
		'{175615, 185923, 195896, 205486, 214644, 223324, 231484, 239081, 246077,
		  252436, 258127, 263120, 267389, 270912, 273671, 275652, 276845, 277243},
		'{-52336, 0, 11652, -65589, -188891, -241113, -120147, 162364, 454487,
		  545949, 314401, -165076, -634978, -801827, -526514, 68943, 657898, 901707},
		'{-3079, -12026, -2264, 28787, 30449, -33139, -85596, -8672, 143225,
		  127268, -141428, -323913, -16253, 555131, 502332, -744129, -2520632,
		  5001922}
	};

	function automatic bank_sel_t bank_of(input logic [1:0] mode);
		bank_sel_t b;
		case (mode)
			MODE_BAND_PASS: b = BANK_BP;
			MODE_HIGH_PASS: b = BANK_HP;
			default:        b = BANK_LP;
		endcase
		return b;
	endfunction

	// Coefficient rounded to nearest from Q1.23 to Q1.(coef_bits-1), sign-extended to 24 bits.
	function automatic logic signed [Q23_BITS-1:0] coef_q(input bank_sel_t b,
			input logic [4:0] idx, input int coef_bits);
		logic signed [Q23_BITS:0] t;
		int s;
		s = Q23_BITS - coef_bits;
		t = (Q23_BITS+1)'(COEF_Q23[b][idx]);
		if (s == 0) begin
			return t[Q23_BITS-1:0];
		end
		t = t + ((Q23_BITS+1)'(1) <<< (s - 1));
		t = t >>> s;
		return t[Q23_BITS-1:0];
	endfunction

endpackage

// ===== rtl/fir_35tap_three_bank_filter_top.sv =====
// Top level of the 35-tap three-bank FIR filter: flow control, mode register and datapath.
`timescale 1ns / 1ps
// A result passes the four stage registers (stages one to three and the result register) in
// turn and waits while the output is stalled. Throughput: one sample per cycle unless the
// output stalls; a stage moves on whenever it is empty or the next one moves.
// Reset (arst_n low, asynchronous) empties the pipeline, clears the delay line to zero and sets
// the filter mode to low-pass. Configuration writes are always accepted.

module fir_35tap_three_bank_filter_top #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          block_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          saturated
);
	import fir3b_pkg::*;

	localparam int ACC_W = SAMPLE_BITS + COEF_BITS + 2;

	pipe_ctl_t                     ctl;
	logic [1:0]                    filter_mode_q;
	logic                          valid_s1;
	logic                          valid_s2;
	logic                          valid_s3;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS:0]   presum_s1 [HALF_TAPS];
	logic [1:0]                    mode_s1;
	logic signed [ACC_W-1:0]       part_s3 [NUM_GROUPS];

	// The mode register takes every write at once. Only the two low bits exist, and the
	// unused code falls back to the low-pass bank in the coefficient selection.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= MODE_LOW_PASS;
		end else if (cfg_valid) begin
			filter_mode_q <= cfg_data;
		end
	end

	// Flow control. Each stage loads when it is empty or when the stage after it is loading
	// too, so a full pipeline moves as a whole whenever the result register is taken. A
	// waiting result does not stop the input side until every stage ahead of it is full.
	always_comb begin
		ctl.load_out = !out_valid_q || out_ready;
		ctl.load_s3  = !valid_s3 || ctl.load_out;
		ctl.load_s2  = !valid_s2 || ctl.load_s3;
		ctl.load_s1  = !valid_s1 || ctl.load_s2;
		ctl.take_in  = in_valid && ctl.load_s1;
	end

	assign in_ready  = ctl.load_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_s1) begin
				valid_s1 <= in_valid;
			end
			if (ctl.load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctl.load_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ctl.load_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	// Stage one: the delay line is updated as each item is taken, and because the bank is
	// symmetric the two samples that share a coefficient are added before multiplication.
	// The mode travels with the item, so a later write never touches one in flight.
	fir3b_tap_line #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_tap_line (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (sample),
		.block_start(block_start),
		.mode       (filter_mode_q),
		.presum_s1  (presum_s1),
		.mode_s1    (mode_s1)
	);

	// Stages two and three: eighteen multipliers, then three partial sums of six products.
	fir3b_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.ACC_W      (ACC_W)
	) u_mac (
		.clk      (clk),
		.ctl      (ctl),
		.presum_s1(presum_s1),
		.mode_s1  (mode_s1),
		.part_s3  (part_s3)
	);

	// Final stage: the exact sum is rounded to the sample format and clamped, with a flag.
	fir3b_round_sat #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.ACC_W      (ACC_W)
	) u_round_sat (
		.clk      (clk),
		.ctl      (ctl),
		.part_s3  (part_s3),
		.filtered (filtered),
		.saturated(saturated)
	);

endmodule

// ===== rtl/fir3b_tap_line.sv =====
// Delay line of past samples and the symmetric pre-adder stage.
`timescale 1ns / 1ps

module fir3b_tap_line #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fir3b_pkg::pipe_ctl_t         ctl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                         block_start,
	input  logic [1:0]                   mode,
	output logic signed [SAMPLE_BITS:0]  presum_s1 [fir3b_pkg::HALF_TAPS],
	output logic [1:0]                   mode_s1
);
	import fir3b_pkg::*;

	logic signed [SAMPLE_BITS-1:0] hist_q [HIST_LEN];
	logic signed [SAMPLE_BITS-1:0] tap [TAPS];

	// A block start makes every older tap look like the new sample.
	always_comb begin
		tap[0] = sample;
		for (int k = 1; k < TAPS; k++) begin
			tap[k] = block_start ? sample : hist_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST_LEN; k++) begin
				hist_q[k] <= '0;
			end
		end else if (ctl.take_in) begin
			for (int k = 0; k < HIST_LEN; k++) begin
				hist_q[k] <= tap[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			for (int i = 0; i < HALF_TAPS - 1; i++) begin
				presum_s1[i] <= (SAMPLE_BITS+1)'(tap[i]) + (SAMPLE_BITS+1)'(tap[TAPS-1-i]);
			end
			presum_s1[HALF_TAPS-1] <= (SAMPLE_BITS+1)'(tap[HALF_TAPS-1]);
			mode_s1 <= mode;
		end
	end

endmodule

// ===== rtl/fir3b_mac.sv =====
// Coefficient multipliers and the first level of the registered adder tree.
`timescale 1ns / 1ps

module fir3b_mac #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int ACC_W       = SAMPLE_BITS + COEF_BITS + 2
) (
	input  logic                        clk,
	input  fir3b_pkg::pipe_ctl_t        ctl,
	input  logic signed [SAMPLE_BITS:0] presum_s1 [fir3b_pkg::HALF_TAPS],
	input  logic [1:0]                  mode_s1,
	output logic signed [ACC_W-1:0]     part_s3 [fir3b_pkg::NUM_GROUPS]
);
	import fir3b_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS + 1;

	bank_sel_t                    bank;
	logic signed [Q23_BITS-1:0]   coef_full [HALF_TAPS];
	logic signed [COEF_BITS-1:0]  coef [HALF_TAPS];
	logic signed [PROD_W-1:0]     prod_s2 [HALF_TAPS];
	logic signed [ACC_W-1:0]      group_sum [NUM_GROUPS];

	always_comb begin
		bank = bank_of(mode_s1);
		for (int i = 0; i < HALF_TAPS; i++) begin
			coef_full[i] = coef_q(bank, 5'(i), COEF_BITS);
			coef[i]      = coef_full[i][COEF_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			for (int i = 0; i < HALF_TAPS; i++) begin
				prod_s2[i] <= PROD_W'(presum_s1[i]) * PROD_W'(coef[i]);
			end
		end
	end

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			group_sum[g] = '0;
			for (int j = 0; j < GROUP_LEN; j++) begin
				group_sum[g] = group_sum[g] + ACC_W'(prod_s2[g*GROUP_LEN+j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				part_s3[g] <= group_sum[g];
			end
		end
	end

endmodule

// ===== rtl/fir3b_round_sat.sv =====
// Final sum, round to nearest and saturation into the result register.
`timescale 1ns / 1ps

module fir3b_round_sat #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int ACC_W       = SAMPLE_BITS + COEF_BITS + 2
) (
	input  logic                          clk,
	input  fir3b_pkg::pipe_ctl_t          ctl,
	input  logic signed [ACC_W-1:0]       part_s3 [fir3b_pkg::NUM_GROUPS],
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          saturated
);
	import fir3b_pkg::*;

	localparam int Y_W = ACC_W - (COEF_BITS - 1);

	logic signed [ACC_W-1:0]       acc;
	logic signed [ACC_W-1:0]       acc_rnd;
	logic signed [ACC_W-1:0]       acc_shr;
	logic signed [Y_W-1:0]         y;
	logic [Y_W-SAMPLE_BITS:0]      y_top;
	logic                          over;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	always_comb begin
		acc = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			acc = acc + part_s3[g];
		end
		// Ties round towards plus infinity.
		acc_rnd = acc + (ACC_W'(1) <<< (COEF_BITS - 2));
		acc_shr = acc_rnd >>> (COEF_BITS - 1);
		y       = acc_shr[Y_W-1:0];
		y_top   = y[Y_W-1:SAMPLE_BITS-1];
		over    = !((&y_top) || (~|y_top));
		if (over) begin
			y_sat = y[Y_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else begin
			y_sat = y[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			filtered  <= y_sat;
			saturated <= over;
		end
	end

endmodule

// ===== rtl/fir3b_checker.sv =====
// Port-level checker for the three-bank FIR filter, bound to its top level.
`timescale 1ns / 1ps

module fir3b_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] filtered,
	input logic                          saturated
);

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// A stalled result holds its value and flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(saturated))
		else $error("result changed while stalled");

	// A clamped result sits at one end of the sample range.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> filtered == S_MAX || filtered == S_MIN)
		else $error("saturated result not at a range limit");

	// With the output side taking results, the input side never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is ready");

endmodule

bind fir_35tap_three_bank_filter_top fir3b_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_fir3b_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.filtered (filtered),
	.saturated(saturated)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the 35-tap three-bank FIR filter top level.
`timescale 1ns / 1ps

module tb;

	import fir3b_pkg::*;

	// Widths used by both the block and the filter model below.
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;

	// The fourth mode code has no bank of its own and must fall back to low-pass.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// A run of this many clock cycles without any handshake means the block has hung.
	localparam int QUIET_LIMIT = 1000;

	// Mismatch reports are capped so that a broken block cannot flood the log.
	localparam int REPORT_CAP = 200;

	// Filter taps, signed Q1.23, first half of each symmetric bank.
	localparam int KAISER_Q23 [NUM_BANKS][HALF_TAPS] = '{
		'{175615, 185923, 195896, 205486, 214644, 223324, 231484, 239081, 246077,
		  252436, 258127, 263120, 267389, 270912, 273671, 275652, 276845, 277243},
		'{-52336, 0, 11652, -65589, -188891, -241113, -120147, 162364, 454487,
		  545949, 314401, -165076, -634978, -801827, -526514, 68943, 657898, 901707},
		'{-3079, -12026, -2264, 28787, 30449, -33139, -85596, -8672, 143225,
		  127268, -141428, -323913, -16253, 555131, 502332, -744129, -2520632,
		  5001922}
	};

	// Kinds of sample content used to fill a block of random samples.
	typedef enum int {
		CONTENT_FULL,
		CONTENT_SMALL,
		CONTENT_EXTREME
	} content_kind_t;

	// One pending input item, with the idle cycles to spend before it is offered.
	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       prime;
		int                         gap;
		bit                         hold;
	} sample_item_t;

	// One expected output item.
	typedef struct {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       saturated;
	} filter_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [1:0]                 cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       block_start;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] filtered;
	logic                       saturated;

	// Model state: the mode register and the 34 previous samples, newest first.
	logic [1:0]                 mode_shadow;
	logic signed [SAMPLE_W-1:0] delay_line [HIST_LEN];

	sample_item_t   pending_samples[$];
	filter_result_t filtered_due[$];

	int errors;
	bit tx_calm;
	bit rx_calm;

	fir_35tap_three_bank_filter_top #(
		.SAMPLE_BITS(SAMPLE_W),
		.COEF_BITS  (COEF_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.block_start(block_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered   (filtered),
		.saturated  (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Tap t of bank b, rounded to nearest from Q1.23 down to the coefficient width.
	// Taps above the centre mirror those below it.
	function automatic longint coef_of(input bank_sel_t b, input int t);
		longint raw;
		int     idx;
		int     s;
		idx = (t < HALF_TAPS) ? t : (TAPS - 1 - t);
		raw = longint'(KAISER_Q23[b][idx]);
		s = Q23_BITS - COEF_W;
		if (s == 0) begin
			return raw;
		end
		return (raw + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Filters one accepted sample: primes the delay line on a block start, forms the
	// exact sum of products, rounds it half up, clamps it and queues the result.
	task automatic filter_sample(input logic signed [SAMPLE_W-1:0] x, input logic prime);
		bank_sel_t      b;
		longint         acc;
		longint         y;
		longint         smax;
		longint         smin;
		filter_result_t r;
		b = (mode_shadow == MODE_BAND_PASS) ? BANK_BP :
		    (mode_shadow == MODE_HIGH_PASS) ? BANK_HP : BANK_LP;
		if (prime) begin
			for (int k = 0; k < HIST_LEN; k++) begin
				delay_line[k] = x;
			end
		end
		acc = coef_of(b, 0) * longint'(x);
		for (int k = 1; k < TAPS; k++) begin
			acc += coef_of(b, k) * longint'(delay_line[k-1]);
		end
		y = (acc + (longint'(1) <<< (COEF_W - 2))) >>> (COEF_W - 1);
		smax = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
		smin = -(longint'(1) <<< (SAMPLE_W - 1));
		r.saturated = 1'b0;
		if (y > smax) begin
			y = smax;
			r.saturated = 1'b1;
		end else if (y < smin) begin
			y = smin;
			r.saturated = 1'b1;
		end
		r.filtered = y[SAMPLE_W-1:0];
		filtered_due.push_back(r);
		for (int k = HIST_LEN - 1; k > 0; k--) begin
			delay_line[k] = delay_line[k-1];
		end
		delay_line[0] = x;
	endtask

	// Sample driver. An item is offered once its idle gap has passed, and a held item
	// is only offered once every result already owed has come out. When a sample is
	// taken and the next one is due at once, in_valid simply stays high.
	always @(posedge clk) begin : sample_driver
		sample_item_t nxt;
		bit           busy;
		int           idle_run;
		if (!arst_n) begin
			in_valid <= 1'b0;
			idle_run = 0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				filter_sample(sample, block_start);
				busy = 1'b0;
				idle_run = 0;
			end
			if (!busy) begin
				if (pending_samples.size() != 0 && idle_run >= pending_samples[0].gap &&
				    (!pending_samples[0].hold || filtered_due.size() == 0)) begin
					nxt = pending_samples.pop_front();
					sample      <= nxt.value;
					block_start <= nxt.prime;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					if (idle_run < QUIET_LIMIT) begin
						idle_run++;
					end
				end
			end
		end
	end

	// Result monitor. Each result taken is checked against the oldest expectation, and
	// after it the receiver draws a fresh random stall, or none in a calm stretch.
	always @(posedge clk) begin : result_monitor
		filter_result_t want;
		int             rx_wait;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (filtered_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP) begin
						$display("%0t ns: unexpected result, expected none, got filtered=%0d saturated=%0b",
						         $time, filtered, saturated);
					end
				end else begin
					want = filtered_due.pop_front();
					if (filtered !== want.filtered) begin
						errors++;
						if (errors <= REPORT_CAP) begin
							$display("%0t ns: filtered mismatch, expected %0d, got %0d",
							         $time, want.filtered, filtered);
						end
					end
					if (saturated !== want.saturated) begin
						errors++;
						if (errors <= REPORT_CAP) begin
							$display("%0t ns: saturated mismatch, expected %0b, got %0b",
							         $time, want.saturated, saturated);
						end
					end
				end
				rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0);
		end
	end

	// Watchdog: any handshake restarts the count, and a long silence ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			    (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
		$display("** fir_35tap_three_bank_filter_top: FAILED **");
		$finish;
	end

	// Queues one sample, drawing its idle gap unless the sender is in a calm stretch.
	task automatic queue_sample(input logic signed [SAMPLE_W-1:0] v, input logic prime,
			input bit hold);
		sample_item_t it;
		it.value = v;
		it.prime = prime;
		it.hold  = hold;
		it.gap   = tx_calm ? 0 : $urandom_range(0, 8);
		pending_samples.push_back(it);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] draw_sample(input content_kind_t kind);
		logic signed [SAMPLE_W-1:0] v;
		case (kind)
			CONTENT_SMALL: begin
				v = SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
			end
			CONTENT_EXTREME: begin
				case ($urandom_range(0, 3))
					0:       v = {1'b0, {(SAMPLE_W-1){1'b1}}};
					1:       v = {1'b1, {(SAMPLE_W-1){1'b0}}};
					2:       v = '1;
					default: v = SAMPLE_W'($urandom);
				endcase
			end
			default: begin
				v = SAMPLE_W'($urandom);
			end
		endcase
		return v;
	endfunction

	// A block that drives the high-pass sum past full scale. The block is primed with
	// the extreme of one sign, which the negative sum of the outer taps turns in favour
	// of the wanted sign, and the next 18 samples match the sign of the taps they land
	// on when the last of them arrives. The final result therefore clamps, towards the
	// top when neg is clear and towards the bottom when it is set.
	task automatic queue_sat_burst(input bit neg);
		logic signed [SAMPLE_W-1:0] top;
		logic signed [SAMPLE_W-1:0] bottom;
		top    = {1'b0, {(SAMPLE_W-1){1'b1}}};
		bottom = {1'b1, {(SAMPLE_W-1){1'b0}}};
		queue_sample(neg ? top : bottom, 1'b1, 1'b0);
		for (int j = 1; j <= HALF_TAPS; j++) begin
			if ((coef_of(BANK_HP, HALF_TAPS - j) >= 0) != neg) begin
				queue_sample(top, 1'b0, 1'b0);
			end else begin
				queue_sample(bottom, 1'b0, 1'b0);
			end
		end
	endtask

	// Random phase of about n samples. Most of it is primed blocks of varied content,
	// with saturating blocks and stray single samples mixed in. The phase opens with an
	// unprimed sample, so the history left by the previous mode is carried into the new
	// bank. Now and then a sample is held back until the filter has drained.
	task automatic queue_random_phase(input int n);
		int            count;
		int            pick;
		int            len;
		content_kind_t kind;
		count = 1;
		queue_sample(draw_sample(CONTENT_FULL), 1'b0, 1'b0);
		while (count < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				queue_sample(draw_sample(CONTENT_FULL), 1'($urandom), 1'b0);
				count++;
			end else if (pick < 16) begin
				queue_sat_burst(1'($urandom));
				count += HALF_TAPS + 1;
			end else begin
				len = $urandom_range(4, 60);
				kind = content_kind_t'($urandom_range(0, 2));
				queue_sample(draw_sample(kind), 1'b1, $urandom_range(0, 9) == 0);
				for (int k = 1; k < len; k++) begin
					queue_sample(draw_sample(kind), 1'b0, $urandom_range(0, 199) == 0);
				end
				count += len;
			end
		end
	endtask

	// Waits until every queued sample has been taken and every result has come out.
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (pending_samples.size() != 0 || in_valid || filtered_due.size() != 0);
	endtask

	// Writes the mode register and updates the model once the write has been taken.
	task automatic write_mode(input logic [1:0] m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		mode_shadow = m;
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [1:0] phase_modes [8];
		phase_modes = '{MODE_BAND_PASS, MODE_UNUSED, MODE_HIGH_PASS, MODE_LOW_PASS,
		                MODE_HIGH_PASS, MODE_BAND_PASS, MODE_UNUSED, MODE_LOW_PASS};
		errors  = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		mode_shadow = MODE_LOW_PASS;
		for (int k = 0; k < HIST_LEN; k++) begin
			delay_line[k] = '0;
		end
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		sample      <= '0;
		block_start <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, first in the reset mode: full-scale samples into the cleared
		// delay line, then primed blocks of zero and of each extreme, with minus one after the last.
		queue_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0, 1'b0);
		queue_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0, 1'b0);
		queue_sample('0, 1'b1, 1'b0);
		queue_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1, 1'b0);
		queue_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1, 1'b0);
		queue_sample('1, 1'b0, 1'b0);
		wait_drained();

		// Then high-pass, where a crafted block must clamp at full scale.
		write_mode(MODE_HIGH_PASS);
		queue_sat_burst(1'b0);
		wait_drained();

		// Random phases, each in its own mode. The fourth runs with no idling on
		// either side, so that samples and results stream back to back.
		foreach (phase_modes[p]) begin
			tx_calm = (p == 3);
			rx_calm = (p == 3);
			write_mode(phase_modes[p]);
			queue_random_phase(95);
			wait_drained();
		end

		// Allow for anything the block might still put out after the last result.
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("** fir_35tap_three_bank_filter_top: PASSED **");
		end else begin
			$display("** fir_35tap_three_bank_filter_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fir3b_pkg.sv
rtl/fir3b_tap_line.sv
rtl/fir3b_mac.sv
rtl/fir3b_round_sat.sv
rtl/fir_35tap_three_bank_filter_top.sv
rtl/fir3b_checker.sv
tb/tb.sv
